// ===== design/upd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg: shared definitions for the URL percent decoder
// Holds the front-end state encoding, the queue entry layout and the
// hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned DEFAULT_FIFO_DEPTH = 4;
    localparam logic [7:0] DIGIT_RADIX = 8'd16;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // what the front end is holding between transactions
    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } held_e_t;

    // one queue entry: up to three decoded bytes of one input transaction
    typedef struct packed {
        logic [1:0]                   cnt;   // number of valid bytes, 1..3
        logic [MAX_RESULTS-1:0][7:0]  data;  // data[0] goes out first
        logic                         last;  // final byte closes the string
    } upd_entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) ||
               (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h61 + LETTER_BASE;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h41 + LETTER_BASE;
        end
        return t[3:0];
    endfunction

    // high digit times the radix plus the low digit
    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [11:0] prod;
        prod = {8'd0, hex_value(hi)} * {4'd0, DIGIT_RADIX};
        return prod[7:0] + {4'd0, hex_value(lo)};
    endfunction

endpackage : upd_pkg
`default_nettype wire

// ===== design/upd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upd_front: escape tracking and classification
// Tracks a pending '%' and hex digit and turns each input transaction into
// one queue entry of up to three bytes, or none.
// ----------------------------------------------------------------------------
module upd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_fire,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    output upd_pkg::upd_entry_t       push_entry,
    output logic                      push
);

    upd_pkg::held_e_t held_reg, held_next;
    logic [7:0]       digit_reg, digit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= upd_pkg::HELD_NONE;
            digit_reg <= 8'd0;
        end else begin
            held_reg  <= held_next;
            digit_reg <= digit_next;
        end
    end

    // next state
    always_comb begin
        held_next  = held_reg;
        digit_next = digit_reg;
        if (in_fire) begin
            unique case (held_reg)
                upd_pkg::HELD_PCT: begin
                    if (upd_pkg::is_hex(in_byte)) begin
                        held_next  = upd_pkg::HELD_DIGIT;
                        digit_next = in_byte;
                    end else begin
                        held_next = (in_byte == upd_pkg::PCT_CHAR) ?
                                    upd_pkg::HELD_PCT : upd_pkg::HELD_NONE;
                    end
                end
                upd_pkg::HELD_DIGIT: begin
                    if (upd_pkg::is_hex(in_byte)) begin
                        held_next = upd_pkg::HELD_NONE;
                    end else begin
                        held_next = (in_byte == upd_pkg::PCT_CHAR) ?
                                    upd_pkg::HELD_PCT : upd_pkg::HELD_NONE;
                    end
                end
                default: begin
                    held_next = (in_byte == upd_pkg::PCT_CHAR) ?
                                upd_pkg::HELD_PCT : upd_pkg::HELD_NONE;
                end
            endcase
            if (in_last) begin
                held_next  = upd_pkg::HELD_NONE;
                digit_next = 8'd0;
            end
        end
    end

    // outputs: build the byte list for this transaction
    always_comb begin
        logic [1:0]       n;
        logic             fresh;
        upd_pkg::held_e_t mid;
        n     = 2'd0;
        fresh = 1'b0;
        mid   = upd_pkg::HELD_NONE;
        push_entry.data = '0;
        unique case (held_reg)
            upd_pkg::HELD_PCT: begin
                if (upd_pkg::is_hex(in_byte)) begin
                    mid = upd_pkg::HELD_DIGIT;
                end else begin
                    push_entry.data[n] = upd_pkg::PCT_CHAR;
                    n     = n + 2'd1;
                    fresh = 1'b1;
                end
            end
            upd_pkg::HELD_DIGIT: begin
                if (upd_pkg::is_hex(in_byte)) begin
                    push_entry.data[n] = upd_pkg::hex_pair(digit_reg, in_byte);
                    n = n + 2'd1;
                end else begin
                    push_entry.data[n] = upd_pkg::PCT_CHAR;
                    n = n + 2'd1;
                    push_entry.data[n] = digit_reg;
                    n     = n + 2'd1;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        if (fresh) begin
            if (in_byte == upd_pkg::PCT_CHAR) begin
                mid = upd_pkg::HELD_PCT;
            end else begin
                push_entry.data[n] = in_byte;
                n = n + 2'd1;
            end
        end
        // flush whatever is still held at the end of the string
        if (in_last) begin
            if (mid != upd_pkg::HELD_NONE) begin
                push_entry.data[n] = upd_pkg::PCT_CHAR;
                n = n + 2'd1;
            end
            if (mid == upd_pkg::HELD_DIGIT) begin
                push_entry.data[n] = in_byte;
                n = n + 2'd1;
            end
        end
        push_entry.cnt  = n;
        push_entry.last = in_last;
        push            = in_fire && (n != 2'd0);
    end

endmodule : upd_front
`default_nettype wire

// ===== design/upd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upd_queue: entry queue between front and back
// Small circular buffer of decoded entries; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::DEFAULT_FIFO_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  upd_pkg::upd_entry_t       push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output upd_pkg::upd_entry_t       head_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    upd_pkg::upd_entry_t mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule : upd_queue
`default_nettype wire

// ===== design/upd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upd_back: result sequencer
// Walks the bytes of the head entry one per result transaction and pops the
// entry after its final byte.
// ----------------------------------------------------------------------------
module upd_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 head_valid,
    input  upd_pkg::upd_entry_t       head_entry,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       final_byte;
    logic       fire;

    assign final_byte = (idx_reg == head_entry.cnt - 2'd1);
    assign m_valid    = head_valid;
    assign m_out_byte = head_entry.data[idx_reg];
    assign m_out_last = head_entry.last && final_byte;
    assign fire       = m_valid && m_ready;
    assign pop        = fire && final_byte;

    always_comb begin
        idx_next = idx_reg;
        if (fire) begin
            idx_next = final_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule : upd_back
`default_nettype wire

// ===== design/url_percent_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes '%' plus two hex digits into one byte, passes other bytes through
// and flushes held escape bytes at the end of each string.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------
//  s_      | in        | s_valid / s_ready  | s_in_byte[7:0], s_in_last
//  m_      | out       | m_valid / m_ready  | m_out_byte[7:0], m_out_last
//
// Cycles: one input transaction per cycle while the queue has room; results
//   leave one byte per cycle while m_ready is high, and the queue absorbs a
//   transaction yielding two or three bytes (failed escape or end of string
//   flush). Each result is registered in the queue before it is offered.
// Reset: aresetn low clears the escape state, the queue and the sequencer.
// Stalls: s_ready drops only while all FIFO_DEPTH queue entries are occupied.
//
module url_percent_decoder #(
    parameter int unsigned FIFO_DEPTH = upd_pkg::DEFAULT_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_in_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_out_last
);

    upd_pkg::upd_entry_t push_entry;
    upd_pkg::upd_entry_t head_entry;
    logic                push;
    logic                full;
    logic                pop;
    logic                head_valid;
    logic                in_fire;

    // accept whenever the queue has a free slot
    assign s_ready = !full;
    assign in_fire = s_valid && s_ready;

    // front: hold escape state and classify each byte
    upd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_byte    (s_in_byte),
        .in_last    (s_in_last),
        .push_entry (push_entry),
        .push       (push)
    );

    // queue: decouple input acceptance from result delivery
    upd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back: advance through the head entry one byte per transaction
    upd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule : url_percent_decoder
`default_nettype wire

// ===== design/upd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// upd_checker: port-level checks for the URL percent decoder
// Watches the top level's ports and flags handshake and flow slips.
// ----------------------------------------------------------------------------
module upd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_in_byte,
    input wire logic        s_in_last,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_out_byte,
    input wire logic        m_out_last
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("stalled result changed");

    // hold a stalled input transaction
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_in_last))
        else $error("stalled input changed");

    // drop all results during reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input backpressure only while results are waiting
    a_ready_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // a last byte always yields at least one result
    a_last_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_in_last |=> m_valid)
        else $error("end of string produced no result");

endmodule : upd_checker

bind url_percent_decoder upd_checker u_upd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_in_byte  (s_in_byte),
    .s_in_last  (s_in_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last)
);
`default_nettype wire

// ===== sim/upd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checker: prediction and comparison for the URL percent decoder
// Watches both channels. Each accepted input transaction is run through a
// local decoder model and its decoded bytes are queued. Each accepted output
// transaction is compared with the oldest queued byte.
// ----------------------------------------------------------------------------
module tb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_out_last,
    output int unsigned fail_count,
    output int unsigned pending
);

    typedef struct {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    decoded_t         decoded_q[$];
    upd_pkg::held_e_t held;
    logic [7:0]       held_char;

    initial begin
        fail_count = 0;
        pending    = 0;
        held       = upd_pkg::HELD_NONE;
        held_char  = 8'h00;
    end

    // {is digit, value}; the low nibble carries the value of '0'..'9', and
    // letters sit nine below their value in both cases
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b1, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // advance the local decoder by one byte and queue what it yields
    task automatic decode_byte(input logic [7:0] b, input logic last);
        decoded_t   run_q[$];
        logic [4:0] lo;
        logic [4:0] hi;
        logic       afresh;
        lo     = digit_of(b);
        hi     = digit_of(held_char);
        afresh = 1'b0;
        case (held)
            upd_pkg::HELD_PCT: begin
                if (lo[4]) begin
                    held_char = b;
                    held      = upd_pkg::HELD_DIGIT;
                end else begin
                    run_q.push_back('{data: upd_pkg::PCT_CHAR, last: 1'b0});
                    afresh = 1'b1;
                end
            end
            upd_pkg::HELD_DIGIT: begin
                if (lo[4]) begin
                    run_q.push_back('{data: {hi[3:0], lo[3:0]}, last: 1'b0});
                    held = upd_pkg::HELD_NONE;
                end else begin
                    run_q.push_back('{data: upd_pkg::PCT_CHAR, last: 1'b0});
                    run_q.push_back('{data: held_char, last: 1'b0});
                    afresh = 1'b1;
                end
            end
            default: begin
                afresh = 1'b1;
            end
        endcase
        if (afresh) begin
            held = upd_pkg::HELD_NONE;
            if (b == upd_pkg::PCT_CHAR) begin
                held = upd_pkg::HELD_PCT;
            end else begin
                run_q.push_back('{data: b, last: 1'b0});
            end
        end
        if (last) begin
            if (held != upd_pkg::HELD_NONE) begin
                run_q.push_back('{data: upd_pkg::PCT_CHAR, last: 1'b0});
            end
            if (held == upd_pkg::HELD_DIGIT) begin
                run_q.push_back('{data: held_char, last: 1'b0});
            end
            held      = upd_pkg::HELD_NONE;
            held_char = 8'h00;
            if (run_q.size() > 0) begin
                run_q[run_q.size()-1].last = 1'b1;
            end
        end
        foreach (run_q[i]) begin
            decoded_q.push_back(run_q[i]);
        end
    endtask

    task automatic compare_byte(input logic [7:0] b, input logic last);
        decoded_t want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("byte %02h last %0b with nothing pending", b, last));
        end else begin
            want = decoded_q.pop_front();
            if (b !== want.data) begin
                report_mismatch($sformatf("byte %02h, predicted %02h", b, want.data));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last %0b on byte %02h, predicted %0b",
                                          last, b, want.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held      = upd_pkg::HELD_NONE;
            held_char = 8'h00;
            decoded_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, s_in_last);
            end
            if (m_valid && m_ready) begin
                compare_byte(m_out_byte, m_out_last);
            end
        end
        pending = decoded_q.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top of the URL percent decoder testbench
// Drives directed escape strings and then random strings, with well-formed
// escapes most often, mixed with broken ones and raw bytes, with random idle bursts on
// both channels. The checker predicts and compares; this module only makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 128;
    localparam int unsigned CALM_ITEMS   = 30;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_out_last;
    int unsigned fail_count;
    int unsigned pending;

    logic        s_took      = 1'b0;
    bit          calm        = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned stall_left;
    logic [7:0]  text_q[$];

    url_percent_decoder i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    tb_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Latch the input handshake at the edge so the driver can read it at the
    // following falling edge without racing the block.
    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[url_percent_decoder] ERROR");
            $finish;
        end
    end

    // Result side: hold ready low in random bursts of random length, none once
    // the run has gone calm.
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one byte, optionally after an idle burst, and hold it until
    // the transaction is taken. Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(negedge aclk); while (!s_took);
        items_sent++;
    endtask

    // Send text_q as one string, flagging its final byte.
    task automatic send_queue();
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic send_text(input string t);
        text_q.delete();
        for (int i = 0; i < t.len(); i++) begin
            text_q.push_back(t[i]);
        end
        send_queue();
    endtask

    // Any of the 22 hex digit characters, both letter cases.
    function automatic logic [7:0] hex_char();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10) begin
            return 8'h30 + k[7:0];
        end
        if (k < 16) begin
            return 8'h61 + k[7:0] - 8'd10;
        end
        return 8'h41 + k[7:0] - 8'd16;
    endfunction

    // A byte that never continues an escape.
    function automatic logic [7:0] breaker_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
        return c;
    endfunction

    // Build a random string in text_q: complete escapes most often, with raw
    // bytes, broken escapes and dangling percent signs mixed in.
    task automatic build_string();
        int unsigned pieces;
        int unsigned r;
        text_q.delete();
        pieces = $urandom_range(1, 5);
        repeat (pieces) begin
            r = $urandom_range(0, 9);
            case (r)
                0, 1, 2, 3: begin
                    text_q.push_back(upd_pkg::PCT_CHAR);
                    text_q.push_back(hex_char());
                    text_q.push_back(hex_char());
                end
                4: begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
                5, 6: begin
                    text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
                end
                7: begin
                    text_q.push_back(upd_pkg::PCT_CHAR);
                    text_q.push_back(breaker_char());
                end
                8: begin
                    text_q.push_back(upd_pkg::PCT_CHAR);
                    text_q.push_back(hex_char());
                    text_q.push_back(breaker_char());
                end
                default: begin
                    text_q.push_back(upd_pkg::PCT_CHAR);
                end
            endcase
        end
    endtask

    initial begin
        int unsigned random_end;
        int unsigned strings_sent;

        // Hold reset and drive every input to a known value.
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'h00;
        s_in_last = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed strings.
        send_text("%00");       // decoded zero byte passes through
        send_text("%fF");       // largest decoded value, mixed case
        send_byte(8'h00, 1'b0); // raw zero byte is ordinary
        send_byte(8'hff, 1'b1); // non-ASCII byte passes through
        send_text("%%9");       // double percent, then flush of '%' and digit
        send_text("%Ag");       // failed escape on the second digit
        send_text("%/");        // failed escape right after the percent
        send_text("%");         // lone percent as the last byte
        send_text("%4%41");     // breaking byte starts a new escape

        // Random strings; go calm for the tail of the run.
        random_end   = items_sent + RANDOM_ITEMS;
        strings_sent = 0;
        while (items_sent < random_end) begin
            if (items_sent + CALM_ITEMS >= random_end) begin
                calm = 1'b1;
            end
            // Drain everything now and then before the next string.
            if (!calm && strings_sent % 8 == 3) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
            end
            build_string();
            send_queue();
            strings_sent++;
        end

        // Drop valid, wait for the last results, then let the block settle.
        calm = 1'b1;
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("[url_percent_decoder] OK");
        end else begin
            $display("[url_percent_decoder] ERROR");
        end
        $finish;
    end

endmodule
